@@ hw/rtl/afc_pkg.sv @@
package afc_pkg;

    // Corner and coefficient formats
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_IN_W   = 16;
    localparam int COEF_W      = COEF_IN_W + 1;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 2;

    // Planes and clip matrix
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_ROWS   = 4;
    localparam int ROW_W      = NUM_ROWS * COEF_IN_W;
    localparam int W_ROW      = NUM_ROWS - 1;
    localparam int PLANE_W    = 3;

    localparam logic [PLANE_W-1:0]    PLANE_NONE = PLANE_W'(NUM_PLANES);
    localparam logic [NUM_PLANES-1:0] ALL_FLAGS  = '1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ROW_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ROW_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ROW_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ROW_3 = CFG_IDX_W'(3);

    // Reset rows: identity matrix, 1.0 on the diagonal
    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(256) << (0 * COEF_IN_W);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(256) << (1 * COEF_IN_W);
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(256) << (2 * COEF_IN_W);
    localparam logic [ROW_W-1:0] ROW3_RST = ROW_W'(256) << (3 * COEF_IN_W);

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Classified corner: one bit per plane set when the corner is on or in front of it
    typedef struct packed {
        logic                  last;
        logic [NUM_PLANES-1:0] front_of;
    } t_cls;

    // Pick coefficient k (x, y, z, w) out of a packed row
    function automatic logic signed [COEF_IN_W-1:0] coef_of(
        input logic [ROW_W-1:0] row,
        input int               k
    );
        coef_of = $signed(row[k*COEF_IN_W +: COEF_IN_W]);
    endfunction

endpackage

@@ hw/rtl/aabb_frustum_cull_top.sv @@
// Bounding-box frustum culling. Corners of a box stream in one per item as
// signed Q8.8 x/y/z, the final one marked by last_corner; that corner alone
// yields a result (visible, and the lowest plane left/right/bottom/top/near/far
// = 0..5 with every corner strictly behind it, 6 when visible). Planes come from
// the clip matrix rows written over the configuration port (always ready); write
// them only while no corner is in flight. One corner is taken every clock while
// the input is not stalled: the front computes eighteen products and six plane
// distances in a three-stage pipeline and pushes a classification into a
// four-entry queue, the back folds it into the plane flags and loads the single
// output register, which the last corner's result reaches through the stage
// registers and the queue. Input stalls only when the queue plus the two corners
// in the pipeline fill its four entries, which only an output stall can cause.
module aabb_frustum_cull_top import afc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_corner_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_z,
    input  logic                          i_last_corner,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_visible,
    output logic [PLANE_W-1:0]            o_reject_plane,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ROW_W-1:0]              i_cfg_data
);

    logic              push;
    t_cls              push_data;
    logic              pop;
    logic              q_valid;
    t_cls              q_data;
    logic [QCNT_W-1:0] q_count;

    // Front: accept and classify corners
    afc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_corner_x    (i_corner_x),
        .i_corner_y    (i_corner_y),
        .i_corner_z    (i_corner_z),
        .i_last_corner (i_last_corner),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    // Queue between front and back
    afc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    // Back: fold flags and deliver results
    afc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_data),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_visible      (o_visible),
        .o_reject_plane (o_reject_plane)
    );

endmodule

@@ hw/rtl/afc_front.sv @@
module afc_front import afc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_corner_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner_z,
    input  logic                          i_last_corner,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ROW_W-1:0]              i_cfg_data,
    input  logic [QCNT_W-1:0]             i_q_count,
    output logic                          o_push,
    output t_cls                          o_push_data
);

    logic [ROW_W-1:0]          r_row [NUM_ROWS];
    logic signed [COEF_W-1:0]  n_coef [NUM_PLANES][NUM_AXES];
    logic signed [COEF_W-1:0]  r_coef [NUM_PLANES][NUM_AXES];
    logic signed [SUM_W-1:0]   n_dterm [NUM_PLANES];
    logic signed [SUM_W-1:0]   r_dterm [NUM_PLANES];

    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic signed [COORD_WIDTH-1:0] r_s1_pt [NUM_AXES];
    logic                          r_s2_valid;
    logic                          r_s2_last;
    logic signed [PROD_W-1:0]      r_prod [NUM_PLANES][NUM_AXES];

    logic [QCNT_W:0] occupancy;
    logic            accept;
    logic [NUM_PLANES-1:0] front_of;

    // Clip matrix registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_RST;
            r_row[1] <= ROW1_RST;
            r_row[2] <= ROW2_RST;
            r_row[3] <= ROW3_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLIP_ROW_0: r_row[0] <= i_cfg_data;
                CFG_CLIP_ROW_1: r_row[1] <= i_cfg_data;
                CFG_CLIP_ROW_2: r_row[2] <= i_cfg_data;
                CFG_CLIP_ROW_3: r_row[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Form plane coefficients: row3 plus row n on even planes, minus on odd planes
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            logic signed [COEF_W-1:0] d;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (p % 2 == 1) begin
                    n_coef[p][k] = COEF_W'(coef_of(r_row[W_ROW], k))
                                 - COEF_W'(coef_of(r_row[p / 2], k));
                end else begin
                    n_coef[p][k] = COEF_W'(coef_of(r_row[W_ROW], k))
                                 + COEF_W'(coef_of(r_row[p / 2], k));
                end
            end
            if (p % 2 == 1) begin
                d = COEF_W'(coef_of(r_row[W_ROW], NUM_AXES))
                  - COEF_W'(coef_of(r_row[p / 2], NUM_AXES));
            end else begin
                d = COEF_W'(coef_of(r_row[W_ROW], NUM_AXES))
                  + COEF_W'(coef_of(r_row[p / 2], NUM_AXES));
            end
            // w term times 1.0 in Q8.8
            n_dterm[p] = SUM_W'(d) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef  <= n_coef;
        r_dterm <= n_dterm;
    end

    // Hold off input while the queue cannot take every corner in flight
    assign occupancy  = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_s1_valid)
                      + (QCNT_W+1)'(r_s2_valid);
    assign o_in_stall = occupancy >= (QCNT_W+1)'(QDEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    // Stage 1: capture the corner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pt[0] <= i_corner_x;
            r_s1_pt[1] <= i_corner_y;
            r_s1_pt[2] <= i_corner_z;
            r_s1_last  <= i_last_corner;
        end
    end

    // Stage 2: eighteen products, one per plane and axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_last <= r_s1_last;
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                    r_prod[p][k] <= r_coef[p][k] * r_s1_pt[k];
                end
            end
        end
    end

    // Stage 3: sum each plane and classify by sign
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            logic signed [SUM_W-1:0] plane_sum;
            plane_sum = SUM_W'(r_prod[p][0]) + SUM_W'(r_prod[p][1])
                      + SUM_W'(r_prod[p][2]) + r_dterm[p];
            front_of[p] = !plane_sum[SUM_W-1];
        end
    end

    assign o_push               = r_s2_valid;
    assign o_push_data.last     = r_s2_last;
    assign o_push_data.front_of = front_of;

endmodule

@@ hw/rtl/afc_queue.sv @@
module afc_queue import afc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_cls              i_push_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_cls              o_data,
    output logic [QCNT_W-1:0] o_count
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < QCNT_W'(QDEPTH)))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

@@ hw/rtl/afc_back.sv @@
module afc_back import afc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cls               i_q_data,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_visible,
    output logic [PLANE_W-1:0] o_reject_plane
);

    logic [NUM_PLANES-1:0] r_flags;
    logic [NUM_PLANES-1:0] n_flags;
    logic                  r_out_valid;
    logic                  r_visible;
    logic [PLANE_W-1:0]    r_reject;
    logic                  out_free;
    logic [PLANE_W-1:0]    first_reject;

    // A last corner waits for room in the output register
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && (!i_q_data.last || out_free);

    // Clear flags of planes the corner is not strictly behind
    assign n_flags = r_flags & ~i_q_data.front_of;

    // Lowest plane still holding every corner behind it
    always_comb begin
        first_reject = PLANE_NONE;
        for (int p = NUM_PLANES - 1; p >= 0; p--) begin
            if (n_flags[p]) begin
                first_reject = PLANE_W'(p);
            end
        end
    end

    // Accumulate flags, re-arm after the last corner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= ALL_FLAGS;
        end else if (o_pop) begin
            if (i_q_data.last) begin
                r_flags <= ALL_FLAGS;
            end else begin
                r_flags <= n_flags;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_pop && i_q_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_data.last) begin
            r_visible <= n_flags == '0;
            r_reject  <= first_reject;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_visible      = r_visible;
    assign o_reject_plane = r_reject;

    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_data.last) |=> (r_flags == ALL_FLAGS))
        else $error("flags not re-armed after last corner");

    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_visible == (o_reject_plane == PLANE_NONE)))
        else $error("visible and reject plane disagree");

    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && i_q_data.last && r_out_valid && i_out_stall) |-> !o_pop)
        else $error("result taken from queue with output register full");

endmodule
